// File: sv/ddpb_pkg.sv
// ----------------------------------------------------------------------------
// Differential drive PWM balancer package
// Item types, stage records, codes and constants that the block's modules use.
// ----------------------------------------------------------------------------
package ddpb_pkg;

    // Counter width default and the fixed width of the gain register.
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int GAIN_WIDTH      = 6;
    localparam logic [GAIN_WIDTH-1:0] GAIN_RESET = 6'd12;

    // Configuration port geometry.
    localparam int PADDR_WIDTH = 3;
    localparam int PDATA_WIDTH = 32;

    // Register indexes (paddr[2] selects the word).
    localparam logic REG_GAIN = 1'b0;

    // Division by ten of a balance product: a magnitude of SAT_LIMIT or more
    // gives a correction of at least 256, which always saturates both wheels.
    // Below that, m * 6554 >> 16 equals m / 10 exactly.
    localparam int SAT_LIMIT      = 2560;
    localparam int SCALE_IN_WIDTH = 12;
    localparam int RECIP_WIDTH    = 13;
    localparam int RECIP_SHIFT    = 16;
    localparam logic [RECIP_WIDTH-1:0] RECIP_TEN = 13'd6554;
    localparam int SCALE_WIDTH    = SCALE_IN_WIDTH + RECIP_WIDTH;

    localparam logic [7:0] DUTY_MAX = 8'd255;

    // Operation codes of an input item.
    typedef enum logic [1:0] {
        OP_LEFT_EDGE  = 2'd0,
        OP_RIGHT_EDGE = 2'd1,
        OP_DRIVE      = 2'd2,
        OP_NONE       = 2'd3
    } t_op;

    // Drive directions; every other code means stop.
    typedef enum logic [3:0] {
        DIR_HALT       = 4'd0,
        DIR_FWD        = 4'd1,
        DIR_BACK       = 4'd2,
        DIR_SPIN_LEFT  = 4'd3,
        DIR_SPIN_RIGHT = 4'd4,
        DIR_FWD_LEFT   = 4'd5,
        DIR_FWD_RIGHT  = 4'd6,
        DIR_BACK_LEFT  = 4'd7,
        DIR_BACK_RIGHT = 4'd8
    } t_dir;

    // Input item.
    typedef struct packed {
        logic [1:0] op;
        logic [3:0] direction;
        logic [7:0] speed;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [7:0] left_forward_duty;
        logic [7:0] left_reverse_duty;
        logic [7:0] right_forward_duty;
        logic [7:0] right_reverse_duty;
        logic       brake_light;
    } t_out_item;

    // Decoded drive command after the first stage.
    typedef struct packed {
        logic signed [8:0] left_speed;
        logic signed [8:0] right_speed;
        logic [7:0]        speed;
        logic              balance;
        logic              brake;
    } t_cmd_stage;

    // Command plus the scaled balance correction after the second stage.
    typedef struct packed {
        t_cmd_stage cmd;
        logic       comp_neg;
        logic       comp_sat;
        logic [7:0] comp_mag;
    } t_bal_stage;

endpackage

// File: sv/ddpb_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style slave holding the balance gain in tenths.
// ----------------------------------------------------------------------------
module ddpb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ddpb_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [ddpb_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [ddpb_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                             pready,
    output logic [ddpb_pkg::GAIN_WIDTH-1:0]  o_gain
);
    import ddpb_pkg::*;

    logic                  w_reg_sel;
    logic [GAIN_WIDTH-1:0] r_gain_tenths;
    logic [GAIN_WIDTH-1:0] n_gain_tenths;
    logic                  w_write;

    // The port never inserts wait states.
    assign pready    = 1'b1;
    assign w_write   = psel && penable && pwrite && pready;
    assign w_reg_sel = paddr[2];

    // Next value of the gain register.
    always_comb begin
        n_gain_tenths = r_gain_tenths;
        if (w_write && (w_reg_sel == REG_GAIN) && (paddr[1:0] == 2'b00)) begin
            n_gain_tenths = pwdata[GAIN_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_tenths <= GAIN_RESET;
        end else begin
            r_gain_tenths <= n_gain_tenths;
        end
    end

    // Read data.
    always_comb begin
        prdata = '0;
        if (w_reg_sel == REG_GAIN) begin
            prdata = {{(PDATA_WIDTH-GAIN_WIDTH){1'b0}}, r_gain_tenths};
        end
    end

    assign o_gain = r_gain_tenths;

endmodule

// File: sv/ddpb_cmd.sv
// ----------------------------------------------------------------------------
// Command stage
// Accepts items, keeps the encoder counters and the brake flag, decodes drive
// commands and multiplies the counter difference by the gain.
// ----------------------------------------------------------------------------
module ddpb_cmd #(
    parameter int COUNT_WIDTH = ddpb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_in_valid,
    output logic                                                o_in_ready,
    input  ddpb_pkg::t_in_item                                  i_in_item,
    input  logic [ddpb_pkg::GAIN_WIDTH-1:0]                     i_gain,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    output ddpb_pkg::t_cmd_stage                                o_cmd,
    output logic signed [COUNT_WIDTH+ddpb_pkg::GAIN_WIDTH-1:0]  o_product
);
    import ddpb_pkg::*;

    localparam int PROD_WIDTH = COUNT_WIDTH + GAIN_WIDTH;

    logic [COUNT_WIDTH-1:0]       r_left_count;
    logic [COUNT_WIDTH-1:0]       r_right_count;
    logic [COUNT_WIDTH-1:0]       n_left_count;
    logic [COUNT_WIDTH-1:0]       n_right_count;
    logic                         r_brake;
    logic                         n_brake;
    logic                         r_valid;
    t_cmd_stage                   r_cmd;
    t_cmd_stage                   n_cmd;
    logic signed [PROD_WIDTH-1:0] r_product;
    logic signed [PROD_WIDTH-1:0] w_product_full;
    logic [COUNT_WIDTH-1:0]       w_diff;
    logic                         w_accept;
    logic                         w_is_stop;
    logic                         w_both_zero;
    logic signed [8:0]            w_full;
    logic signed [8:0]            w_slow;

    assign o_in_ready = !r_valid || i_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    // Wheel speeds from the direction; the inner wheel runs at half speed.
    assign w_full = $signed({1'b0, i_in_item.speed});
    assign w_slow = $signed({2'b00, i_in_item.speed[7:1]});

    always_comb begin
        n_cmd       = '0;
        w_is_stop   = 1'b0;
        case (t_dir'(i_in_item.direction))
            DIR_FWD: begin
                n_cmd.left_speed  = w_full;
                n_cmd.right_speed = w_full;
            end
            DIR_BACK: begin
                n_cmd.left_speed  = -w_full;
                n_cmd.right_speed = -w_full;
            end
            DIR_SPIN_LEFT: begin
                n_cmd.left_speed  = -w_full;
                n_cmd.right_speed = w_full;
            end
            DIR_SPIN_RIGHT: begin
                n_cmd.left_speed  = w_full;
                n_cmd.right_speed = -w_full;
            end
            DIR_FWD_LEFT: begin
                n_cmd.left_speed  = w_slow;
                n_cmd.right_speed = w_full;
            end
            DIR_FWD_RIGHT: begin
                n_cmd.left_speed  = w_full;
                n_cmd.right_speed = w_slow;
            end
            DIR_BACK_LEFT: begin
                n_cmd.left_speed  = -w_slow;
                n_cmd.right_speed = -w_full;
            end
            DIR_BACK_RIGHT: begin
                n_cmd.left_speed  = -w_full;
                n_cmd.right_speed = -w_slow;
            end
            default: begin
                w_is_stop = 1'b1;
            end
        endcase
        // Equal positive speeds only arise from a forward move at nonzero speed.
        n_cmd.balance = (t_dir'(i_in_item.direction) == DIR_FWD) &&
                        (i_in_item.speed != 8'd0);
        n_cmd.speed   = i_in_item.speed;

        // Brake flag after a drive command. A balanced command always leaves
        // one wheel turning, so the pre-balance speeds decide it.
        n_brake = r_brake;
        if (w_is_stop) begin
            n_brake = 1'b1;
        end else if ((n_cmd.left_speed != 9'sd0) || (n_cmd.right_speed != 9'sd0)) begin
            n_brake = 1'b0;
        end
        n_cmd.brake = n_brake;
    end

    assign w_both_zero = (n_cmd.left_speed == 9'sd0) && (n_cmd.right_speed == 9'sd0);

    // Counter updates.
    always_comb begin
        n_left_count  = r_left_count;
        n_right_count = r_right_count;
        case (t_op'(i_in_item.op))
            OP_LEFT_EDGE: begin
                n_left_count = r_left_count + COUNT_WIDTH'(1);
            end
            OP_RIGHT_EDGE: begin
                n_right_count = r_right_count + COUNT_WIDTH'(1);
            end
            OP_DRIVE: begin
                if (w_both_zero) begin
                    n_left_count  = '0;
                    n_right_count = '0;
                end
            end
            default: begin
            end
        endcase
    end

    // Signed counter difference times the gain.
    assign w_diff         = r_left_count - r_right_count;
    assign w_product_full = $signed(w_diff) * $signed({1'b0, i_gain});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_count  <= '0;
            r_right_count <= '0;
            r_brake       <= 1'b1;
            r_valid       <= 1'b0;
        end else begin
            if (w_accept) begin
                r_left_count  <= n_left_count;
                r_right_count <= n_right_count;
                if (t_op'(i_in_item.op) == OP_DRIVE) begin
                    r_brake <= n_brake;
                end
                r_valid <= (t_op'(i_in_item.op) == OP_DRIVE);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= n_cmd;
            r_product <= w_product_full;
        end
    end

    assign o_valid   = r_valid;
    assign o_cmd     = r_cmd;
    assign o_product = r_product;

endmodule

// File: sv/ddpb_scale.sv
// ----------------------------------------------------------------------------
// Scale stage
// Divides the balance product by ten, truncating toward zero, and flags
// corrections large enough to saturate both wheels.
// ----------------------------------------------------------------------------
module ddpb_scale #(
    parameter int COUNT_WIDTH = ddpb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                                i_clk,
    input  logic                                                i_rst_n,
    input  logic                                                i_valid,
    output logic                                                o_ready,
    input  ddpb_pkg::t_cmd_stage                                i_cmd,
    input  logic signed [COUNT_WIDTH+ddpb_pkg::GAIN_WIDTH-1:0]  i_product,
    output logic                                                o_valid,
    input  logic                                                i_ready,
    output ddpb_pkg::t_bal_stage                                o_bal
);
    import ddpb_pkg::*;

    localparam int PROD_WIDTH = COUNT_WIDTH + GAIN_WIDTH;

    logic                   r_valid;
    t_bal_stage             r_bal;
    t_bal_stage             n_bal;
    logic                   w_neg;
    logic [PROD_WIDTH-1:0]  w_mag;
    logic [SCALE_WIDTH-1:0] w_scaled;
    logic                   w_accept;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Magnitude of the product and reciprocal multiply by one tenth.
    assign w_neg    = i_product[PROD_WIDTH-1];
    assign w_mag    = w_neg ? PROD_WIDTH'(-i_product) : PROD_WIDTH'(i_product);
    assign w_scaled = {{RECIP_WIDTH{1'b0}}, w_mag[SCALE_IN_WIDTH-1:0]} *
                      {{SCALE_IN_WIDTH{1'b0}}, RECIP_TEN};

    always_comb begin
        n_bal          = '0;
        n_bal.cmd      = i_cmd;
        n_bal.comp_neg = w_neg;
        n_bal.comp_sat = (w_mag >= PROD_WIDTH'(SAT_LIMIT));
        n_bal.comp_mag = w_scaled[RECIP_SHIFT +: 8];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_bal <= n_bal;
        end
    end

    assign o_valid = r_valid;
    assign o_bal   = r_bal;

endmodule

// File: sv/ddpb_duty.sv
// ----------------------------------------------------------------------------
// Duty stage
// Applies the balance correction with clamping and splits each wheel speed
// into forward and reverse H-bridge duties; holds the result item.
// ----------------------------------------------------------------------------
module ddpb_duty (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  ddpb_pkg::t_bal_stage i_bal,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ddpb_pkg::t_out_item  o_item
);
    import ddpb_pkg::*;

    logic              r_valid;
    t_out_item         r_item;
    t_out_item         n_item;
    logic              w_accept;
    logic [8:0]        w_up_sum;
    logic [7:0]        w_up;
    logic [7:0]        w_down;
    logic [7:0]        w_bal_left;
    logic [7:0]        w_bal_right;
    logic signed [8:0] w_left;
    logic signed [8:0] w_right;
    logic signed [8:0] w_left_neg;
    logic signed [8:0] w_right_neg;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // Speed plus and minus the correction, clamped to the duty range.
    assign w_up_sum = {1'b0, i_bal.cmd.speed} + {1'b0, i_bal.comp_mag};
    assign w_up     = w_up_sum[8] ? DUTY_MAX : w_up_sum[7:0];
    assign w_down   = (i_bal.comp_mag > i_bal.cmd.speed) ? 8'd0 :
                      (i_bal.cmd.speed - i_bal.comp_mag);

    // A positive correction slows the left wheel and speeds up the right one.
    always_comb begin
        if (i_bal.comp_sat) begin
            w_bal_left  = i_bal.comp_neg ? DUTY_MAX : 8'd0;
            w_bal_right = i_bal.comp_neg ? 8'd0 : DUTY_MAX;
        end else begin
            w_bal_left  = i_bal.comp_neg ? w_up : w_down;
            w_bal_right = i_bal.comp_neg ? w_down : w_up;
        end
    end

    assign w_left      = i_bal.cmd.balance ? $signed({1'b0, w_bal_left}) :
                         i_bal.cmd.left_speed;
    assign w_right     = i_bal.cmd.balance ? $signed({1'b0, w_bal_right}) :
                         i_bal.cmd.right_speed;
    assign w_left_neg  = -w_left;
    assign w_right_neg = -w_right;

    // Sign selects the forward or reverse input of each bridge.
    always_comb begin
        n_item                    = '0;
        n_item.left_forward_duty  = (w_left > 9'sd0) ? w_left[7:0] : 8'd0;
        n_item.left_reverse_duty  = (w_left < 9'sd0) ? w_left_neg[7:0] : 8'd0;
        n_item.right_forward_duty = (w_right > 9'sd0) ? w_right[7:0] : 8'd0;
        n_item.right_reverse_duty = (w_right < 9'sd0) ? w_right_neg[7:0] : 8'd0;
        n_item.brake_light        = i_bal.cmd.brake;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_accept) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: sv/differential_drive_pwm_balancer_core.sv
// ----------------------------------------------------------------------------
// Differential drive PWM balancer
// Encoder counting, drive command decoding, wheel balancing and PWM duty split.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle unless the pipeline is stalled.
// Encoder edge items update the left or right pulse counter at the cycle
// they are accepted and give no result. A drive command passes through the
// stage registers in order: the first stage decodes the direction and
// multiplies the counter difference by the gain, the second divides that
// product by ten through a reciprocal multiply, and the third applies the
// correction with clamping, splits the speeds into forward and reverse
// duties and presents the result item. Each stage holds its own valid bit,
// so input items keep flowing while a result waits to be taken until all
// three stages are full. The gain register sits at byte address 0 and
// should only be written while no drive command is in flight.
module differential_drive_pwm_balancer_core #(
    parameter int COUNT_WIDTH = ddpb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  ddpb_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output ddpb_pkg::t_out_item              o_out_item,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ddpb_pkg::PADDR_WIDTH-1:0] paddr,
    input  logic [ddpb_pkg::PDATA_WIDTH-1:0] pwdata,
    output logic [ddpb_pkg::PDATA_WIDTH-1:0] prdata,
    output logic                             pready
);
    import ddpb_pkg::*;

    localparam int PROD_WIDTH = COUNT_WIDTH + GAIN_WIDTH;

    logic [GAIN_WIDTH-1:0]        w_gain;
    logic                         w_cmd_valid;
    logic                         w_cmd_ready;
    t_cmd_stage                   w_cmd;
    logic signed [PROD_WIDTH-1:0] w_product;
    logic                         w_bal_valid;
    logic                         w_bal_ready;
    t_bal_stage                   w_bal;

    // Configuration registers.
    ddpb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_gain  (w_gain)
    );

    // Counters, decode and balance product.
    ddpb_cmd #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_cmd (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_gain     (w_gain),
        .o_valid    (w_cmd_valid),
        .i_ready    (w_cmd_ready),
        .o_cmd      (w_cmd),
        .o_product  (w_product)
    );

    // Division of the product by ten.
    ddpb_scale #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_cmd_valid),
        .o_ready   (w_cmd_ready),
        .i_cmd     (w_cmd),
        .i_product (w_product),
        .o_valid   (w_bal_valid),
        .i_ready   (w_bal_ready),
        .o_bal     (w_bal)
    );

    // Balance, clamp and duty split.
    ddpb_duty u_duty (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bal_valid),
        .o_ready (w_bal_ready),
        .i_bal   (w_bal),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

    // A bridge never drives forward and reverse of one wheel together.
    a_no_shoot_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            !((o_out_item.left_forward_duty != 8'd0) &&
              (o_out_item.left_reverse_duty != 8'd0)) &&
            !((o_out_item.right_forward_duty != 8'd0) &&
              (o_out_item.right_reverse_duty != 8'd0)))
        else $error("both bridge inputs of one wheel driven");

    // A turning wheel means the brake light is off.
    a_brake_off_when_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid &&
         ((o_out_item.left_forward_duty != 8'd0) ||
          (o_out_item.left_reverse_duty != 8'd0) ||
          (o_out_item.right_forward_duty != 8'd0) ||
          (o_out_item.right_reverse_duty != 8'd0))) |->
            !o_out_item.brake_light)
        else $error("brake light on while a wheel is driven");

    // The input side only stalls when the result side is stalled.
    a_stall_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (o_out_valid && !i_out_ready && w_cmd_valid && w_bal_valid))
        else $error("input stalled without a full pipeline");

endmodule
